@@ src/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg
// Types and constants shared by the sharing access tracker modules.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int LINE_BYTES    = 64;
    localparam int GRANULE_BYTES = 8;
    localparam int LINE_SH       = 6;
    localparam int GRAN_SH       = 3;
    localparam int GPL           = LINE_BYTES / GRANULE_BYTES;
    localparam int ADDR_W        = 48;
    localparam int LINE_W        = ADDR_W - LINE_SH;
    localparam int STAMP_W       = 32;

    localparam logic [1:0] ACT_UPDATE  = 2'd0;
    localparam logic [1:0] ACT_CHECK   = 2'd1;
    localparam logic [1:0] ACT_PRIVATE = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    localparam logic CFG_OPT_READERS = 1'b0;
    localparam logic CFG_SET_LOW     = 1'b1;

    localparam int FLAG_TS  = 0;
    localparam int FLAG_PRV = 1;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
        logic [2:0]        core_id;
        logic [6:0]        byte_count;
        logic              is_read;
        logic [7:0]        read_granules;
        logic [7:0]        write_granules;
    } in_t;

    typedef struct packed {
        logic              hit;
        logic              conflict;
        logic              privatized;
        logic              victim_valid;
        logic [LINE_W-1:0] victim_line;
    } out_t;

    typedef struct packed {
        logic               valid;
        logic [LINE_W-1:0]  tag;
        logic [1:0]         flags;
        logic [STAMP_W-1:0] stamp;
    } tag_ent_t;

    typedef struct packed {
        logic       present;
        logic       wv;
        logic [2:0] wr;
        logic       rv;
        logic [2:0] rd;
        logic       multi;
        logic [7:0] sharers;
    } gran_t;

    typedef gran_t [GPL-1:0] gran_row_t;

    typedef struct packed {
        logic           is_check;
        logic           opt;
        logic           is_read;
        logic [2:0]     core;
        logic [GPL-1:0] span;
        logic [GPL-1:0] rmask;
        logic [GPL-1:0] wmask;
    } upd_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MOD,
        S_CLEAR
    } state_t;

endpackage

@@ src/sat_tag_ram.sv @@
// ----------------------------------------------------------------------------
// sat_tag_ram
// Set memory: one row per set holding valid bit, tag, flags and stamp of
// every way.
// ----------------------------------------------------------------------------
module sat_tag_ram #(
    parameter int NUM_SETS = 64,
    parameter int WAYS     = 8,
    parameter int SET_AW   = 6
) (
    input  logic                           clk,
    input  logic                           re,
    input  logic [SET_AW-1:0]              raddr,
    output sat_pkg::tag_ent_t [WAYS-1:0]   rdata,
    input  logic                           we,
    input  logic [SET_AW-1:0]              waddr,
    input  sat_pkg::tag_ent_t [WAYS-1:0]   wdata
);

    sat_pkg::tag_ent_t [WAYS-1:0] mem [NUM_SETS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/sat_meta_ram.sv @@
// ----------------------------------------------------------------------------
// sat_meta_ram
// Granule memory: one row per entry with the metadata of every granule.
// ----------------------------------------------------------------------------
module sat_meta_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                clk,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output sat_pkg::gran_row_t  rdata,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  sat_pkg::gran_row_t  wdata
);

    sat_pkg::gran_row_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/sat_gran_update.sv @@
// ----------------------------------------------------------------------------
// sat_gran_update
// Per-granule update of one entry row for a metadata update or a request
// conflict check, with the true-sharing and conflict results.
// ----------------------------------------------------------------------------
module sat_gran_update (
    input  sat_pkg::upd_ctl_t  ctl,
    input  sat_pkg::gran_row_t row_in,
    output sat_pkg::gran_row_t row_out,
    output logic               ts,
    output logic               conflict
);

    logic [sat_pkg::GPL-1:0] c_vec;
    logic [sat_pkg::GPL-1:0] t1_vec;
    logic [sat_pkg::GPL-1:0] tu_vec;
    logic [sat_pkg::GPL-1:0] rd_vec;
    logic [sat_pkg::GPL-1:0] wr_vec;
    logic [7:0]              own_bit;

    assign own_bit = 8'(1) << ctl.core;

    always_comb
    begin
        for (int i = 0; i < sat_pkg::GPL; i++)
        begin
            logic wvo;
            logic rdo;
            logic sho;
            wvo = row_in[i].wv && (row_in[i].wr != ctl.core);
            rdo = row_in[i].multi || (row_in[i].rv && (row_in[i].rd != ctl.core));
            sho = (row_in[i].sharers & ~own_bit) != 8'd0;
            c_vec[i]  = ctl.span[i] && row_in[i].present
                        && (wvo || (!ctl.opt && !ctl.is_read && sho));
            t1_vec[i] = ctl.span[i] && row_in[i].present
                        && (c_vec[i] || (ctl.opt && !ctl.is_read
                            && (row_in[i].multi || !row_in[i].rv
                                || (row_in[i].rd != ctl.core))));
            rd_vec[i] = ctl.is_check ? (ctl.span[i] && ctl.is_read) : ctl.rmask[i];
            wr_vec[i] = ctl.is_check ? (ctl.span[i] && !ctl.is_read) : ctl.wmask[i];
            // Reads and writes of one update are judged against the row as it was before it.
            tu_vec[i] = row_in[i].present
                        && ((wvo && (rd_vec[i] || wr_vec[i]))
                            || (wr_vec[i] && (ctl.opt ? rdo : sho)));
        end
    end

    always_comb
    begin
        logic unblocked;
        logic ts1;
        unblocked = 1'b1;
        ts1       = 1'b0;
        // For a check, granules past the first conflicting one add nothing to true sharing.
        for (int i = 0; i < sat_pkg::GPL; i++)
        begin
            ts1       = ts1 || (t1_vec[i] && unblocked);
            unblocked = unblocked && !c_vec[i];
        end
        conflict = ctl.is_check && (c_vec != '0);
        ts       = ctl.is_check ? ts1 : (tu_vec != '0);
    end

    always_comb
    begin
        row_out = row_in;
        if (!conflict)
        begin
            for (int i = 0; i < sat_pkg::GPL; i++)
            begin
                if (rd_vec[i] || wr_vec[i])
                begin
                    row_out[i].present = 1'b1;
                end
                if (wr_vec[i])
                begin
                    row_out[i].wv = 1'b1;
                    row_out[i].wr = ctl.core;
                end
                if (rd_vec[i])
                begin
                    if (ctl.opt)
                    begin
                        if (!row_in[i].multi)
                        begin
                            if (row_in[i].rv && (row_in[i].rd != ctl.core))
                            begin
                                row_out[i].multi = 1'b1;
                            end
                            else
                            begin
                                row_out[i].rv = 1'b1;
                                row_out[i].rd = ctl.core;
                            end
                        end
                    end
                    else
                    begin
                        row_out[i].sharers = row_in[i].sharers | own_bit;
                    end
                end
            end
        end
    end

endmodule

@@ src/sharing_access_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// sharing_access_tracker_unit
// Set-associative table that tracks per-granule writers and readers of lines
// and answers metadata updates, conflict checks and privatization checks.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  input     start, busy, item                start in, busy out
//  result    done, result                     out, one-cycle strobe
//  config    cfg_we, cfg_index, cfg_data      in, written at once
//
// At an item's accepting edge the set memory read lands; in the look state
// the granule memory is read, in the modify state the update and write-back
// of both memories happen, and the result strobe is up in the idle state that
// follows. Busy is high in the look and modify states, so the next item can be
// accepted at the edge that ends the strobe cycle.
// After reset a clearing pass writes one set row per cycle, set rows 0 to
// 2**floor(log2 NUM_SETS)-1, with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sharing_access_tracker_unit #(
    parameter int NUM_SETS = 64,
    parameter int WAYS     = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sat_pkg::in_t  item,
    output logic          done,
    output sat_pkg::out_t result,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [5:0]    cfg_data
);

    localparam int SET_W  = $clog2(NUM_SETS + 1) - 1;
    localparam int SET_AW = (SET_W > 0) ? SET_W : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MDEPTH = NUM_SETS * WAYS;
    localparam int MA_W   = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam logic [MA_W-1:0] WAYS_M = MA_W'(WAYS);
    localparam int CLR_LAST = (SET_W > 0) ? ((1 << SET_W) - 1) : 0;

    sat_pkg::state_t state_reg, state_next;
    sat_pkg::in_t    item_reg;
    logic [SET_AW-1:0] set_reg;
    logic [SET_AW-1:0] clr_reg;
    logic              opt_reg;
    logic [5:0]        low_reg;
    logic [sat_pkg::STAMP_W-1:0] count_reg;

    logic              hit_reg;
    logic [WAY_W-1:0]  way_reg;
    logic              vic_valid_reg;
    logic [sat_pkg::LINE_W-1:0] vic_line_reg;
    sat_pkg::tag_ent_t [WAYS-1:0] row_reg;

    logic          done_reg;
    sat_pkg::out_t result_reg;

    logic [sat_pkg::ADDR_W-1:0] shifted;
    logic [SET_AW-1:0]          set_in;

    sat_pkg::tag_ent_t [WAYS-1:0] tag_rdata;
    sat_pkg::tag_ent_t [WAYS-1:0] tag_wdata;
    logic                         tag_we;
    logic [SET_AW-1:0]            tag_waddr;

    sat_pkg::gran_row_t meta_rdata;
    sat_pkg::gran_row_t meta_wdata;
    sat_pkg::gran_row_t row_base;
    sat_pkg::gran_row_t row_upd;
    logic               meta_we;
    logic [MA_W-1:0]    meta_raddr;
    logic [MA_W-1:0]    meta_waddr;

    logic              look_hit;
    logic [WAY_W-1:0]  look_way;
    logic              look_vv;

    sat_pkg::upd_ctl_t ctl;
    logic              upd_ts;
    logic              upd_conflict;
    logic [7:0]        end_byte;
    logic [2:0]        first_g;
    logic [2:0]        last_g;

    logic [1:0]                  flags_new;
    logic [sat_pkg::STAMP_W-1:0] stamp_new;
    sat_pkg::out_t               res_next;

    assign shifted = item.address >> low_reg;
    assign set_in  = (SET_W == 0) ? '0 : shifted[SET_AW-1:0];

    assign tag_waddr = (state_reg == sat_pkg::S_CLEAR) ? clr_reg : set_reg;

    sat_tag_ram #(
        .NUM_SETS (NUM_SETS),
        .WAYS     (WAYS),
        .SET_AW   (SET_AW)
    ) u_tag (
        .clk    (clk),
        .re     (state_reg == sat_pkg::S_IDLE && start),
        .raddr  (set_in),
        .rdata  (tag_rdata),
        .we     (tag_we),
        .waddr  (tag_waddr),
        .wdata  (tag_wdata)
    );

    // Hit search, then the lowest free way, then the oldest stamp.
    always_comb
    begin
        logic found;
        logic [sat_pkg::STAMP_W-1:0] best;
        look_hit = 1'b0;
        look_way = '0;
        found    = 1'b0;
        best     = tag_rdata[0].stamp;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!look_hit && tag_rdata[w].valid
                && tag_rdata[w].tag == item_reg.address[sat_pkg::ADDR_W-1:sat_pkg::LINE_SH])
            begin
                look_hit = 1'b1;
                look_way = WAY_W'(w);
            end
        end
        if (!look_hit)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (!found && !tag_rdata[w].valid)
                begin
                    found    = 1'b1;
                    look_way = WAY_W'(w);
                end
            end
            if (!found)
            begin
                for (int w = 1; w < WAYS; w++)
                begin
                    if (tag_rdata[w].stamp < best)
                    begin
                        best     = tag_rdata[w].stamp;
                        look_way = WAY_W'(w);
                    end
                end
            end
        end
        look_vv = !look_hit && !found;
    end

    assign meta_raddr = MA_W'(set_reg) * WAYS_M + MA_W'(look_way);
    assign meta_waddr = MA_W'(set_reg) * WAYS_M + MA_W'(way_reg);

    sat_meta_ram #(
        .DEPTH (MDEPTH),
        .AW    (MA_W)
    ) u_meta (
        .clk   (clk),
        .re    (state_reg == sat_pkg::S_LOOK),
        .raddr (meta_raddr),
        .rdata (meta_rdata),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata)
    );

    // A freshly allocated entry starts from cleared metadata.
    assign row_base = hit_reg ? meta_rdata : '0;

    assign end_byte = {2'b00, item_reg.address[5:0]} + {1'b0, item_reg.byte_count} - 8'd1;
    assign first_g  = item_reg.address[5:3];
    assign last_g   = (end_byte[7:3] >= 5'd7) ? 3'd7 : end_byte[5:3];

    always_comb
    begin
        ctl.is_check = item_reg.action == sat_pkg::ACT_CHECK;
        ctl.opt      = opt_reg;
        ctl.is_read  = item_reg.is_read;
        ctl.core     = item_reg.core_id;
        ctl.rmask    = item_reg.read_granules;
        ctl.wmask    = item_reg.write_granules;
        for (int i = 0; i < sat_pkg::GPL; i++)
        begin
            ctl.span[i] = (item_reg.byte_count != 7'd0)
                          && (3'(i) >= first_g) && (3'(i) <= last_g);
        end
    end

    sat_gran_update u_upd (
        .ctl      (ctl),
        .row_in   (row_base),
        .row_out  (row_upd),
        .ts       (upd_ts),
        .conflict (upd_conflict)
    );

    assign stamp_new = count_reg + 32'd1;

    // Write-back and result of the modify state, and the row clearing of the clear state.
    always_comb
    begin
        tag_we     = 1'b0;
        meta_we    = 1'b0;
        meta_wdata = row_upd;
        tag_wdata  = row_reg;
        flags_new  = hit_reg ? row_reg[way_reg].flags : 2'b00;
        res_next   = '0;
        if (state_reg == sat_pkg::S_CLEAR)
        begin
            tag_we    = 1'b1;
            tag_wdata = '0;
        end
        else if (state_reg == sat_pkg::S_MOD)
        begin
            case (item_reg.action) inside
                sat_pkg::ACT_PRIVATE:
                begin
                    res_next.hit = hit_reg;
                    if (hit_reg)
                    begin
                        tag_we = 1'b1;
                        if (!flags_new[sat_pkg::FLAG_TS])
                        begin
                            flags_new[sat_pkg::FLAG_PRV] = 1'b1;
                            res_next.privatized = 1'b1;
                        end
                        else
                        begin
                            flags_new = 2'b00;
                            meta_we   = 1'b1;
                            for (int i = 0; i < sat_pkg::GPL; i++)
                            begin
                                meta_wdata[i]         = '0;
                                meta_wdata[i].present = meta_rdata[i].present;
                            end
                        end
                        tag_wdata[way_reg].flags = flags_new;
                        tag_wdata[way_reg].stamp = stamp_new;
                    end
                end
                sat_pkg::ACT_UPDATE, sat_pkg::ACT_CHECK:
                begin
                    tag_we  = 1'b1;
                    meta_we = 1'b1;
                    if (upd_ts)
                    begin
                        flags_new[sat_pkg::FLAG_TS] = 1'b1;
                    end
                    tag_wdata[way_reg].valid = 1'b1;
                    tag_wdata[way_reg].tag =
                        item_reg.address[sat_pkg::ADDR_W-1:sat_pkg::LINE_SH];
                    tag_wdata[way_reg].flags = flags_new;
                    tag_wdata[way_reg].stamp = stamp_new;
                    res_next.hit          = hit_reg;
                    res_next.conflict     = upd_conflict;
                    res_next.victim_valid = vic_valid_reg;
                    res_next.victim_line  = vic_valid_reg ? vic_line_reg : '0;
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sat_pkg::S_CLEAR:
            begin
                if (clr_reg == SET_AW'(CLR_LAST))
                begin
                    state_next = sat_pkg::S_IDLE;
                end
            end
            sat_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = sat_pkg::S_LOOK;
                end
            end
            sat_pkg::S_LOOK:
            begin
                state_next = sat_pkg::S_MOD;
            end
            sat_pkg::S_MOD:
            begin
                state_next = sat_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sat_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        unique case (state_reg)
            sat_pkg::S_IDLE:  busy = 1'b0;
            sat_pkg::S_LOOK:  busy = 1'b1;
            sat_pkg::S_MOD:   busy = 1'b1;
            sat_pkg::S_CLEAR: busy = 1'b1;
            default:          busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sat_pkg::S_CLEAR;
            clr_reg   <= '0;
            opt_reg   <= 1'b0;
            low_reg   <= 6'd6;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == sat_pkg::S_MOD;
            if (state_reg == sat_pkg::S_CLEAR)
            begin
                clr_reg <= clr_reg + SET_AW'(1);
            end
            if (state_reg == sat_pkg::S_MOD && item_reg.action != sat_pkg::ACT_NONE)
            begin
                count_reg <= stamp_new;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sat_pkg::CFG_OPT_READERS: opt_reg <= cfg_data[0];
                    sat_pkg::CFG_SET_LOW:     low_reg <= cfg_data;
                    default:                  opt_reg <= opt_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sat_pkg::S_IDLE && start)
        begin
            item_reg <= item;
            set_reg  <= set_in;
        end
        if (state_reg == sat_pkg::S_LOOK)
        begin
            hit_reg       <= look_hit;
            way_reg       <= look_way;
            vic_valid_reg <= look_vv;
            vic_line_reg  <= tag_rdata[look_way].tag;
            row_reg       <= tag_rdata;
        end
        if (state_reg == sat_pkg::S_MOD)
        begin
            result_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_mod: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == sat_pkg::S_MOD))
        else $error("result strobe without a finished item");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the unit busy");

    a_victim_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.victim_valid) |-> !result.hit)
        else $error("victim reported on a hit");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.privatized && result.conflict))
        else $error("privatized and conflict together");

endmodule
